// File: rtl/core/dddc_pkg.sv
`default_nettype none

package dddc_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_WIDTH = 2;
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_DEBOUNCE_TIME = 2'd0,
		CFG_PAIR_WINDOW   = 2'd1
	} cfg_index_t;

	// Register and stream widths
	localparam int unsigned CFG_WIDTH     = 16;
	localparam int unsigned NOW_WIDTH     = 32;
	localparam int unsigned S_TDATA_WIDTH = 40;
	localparam int unsigned M_TDATA_WIDTH = 8;

	// Input tdata bit positions
	localparam int unsigned FIRST_RAW_BIT  = 32;
	localparam int unsigned SECOND_RAW_BIT = 33;

	// Poll item kinds carried in s_tuser
	localparam logic FUNC_POLL   = 1'b0;
	localparam logic FUNC_CANCEL = 1'b1;

	// Button selector
	localparam logic BUTTON_FIRST  = 1'b0;
	localparam logic BUTTON_SECOND = 1'b1;

	// Per-lane control from the merge stage
	typedef struct packed {
		logic upd;
		logic cancel;
	} lane_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/dddc_lane.sv
`default_nettype none

module dddc_lane
	import dddc_pkg::*;
#(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lane_ctrl_t            ctrl,
	input  wire logic [TIME_WIDTH-1:0] now_t,
	input  wire logic                  raw,
	input  wire logic [TIME_WIDTH-1:0] debounce_t,
	input  wire logic [TIME_WIDTH-1:0] window_t,
	output logic                       fire
);

	logic                  level_q;
	logic [TIME_WIDTH-1:0] start_q;
	logic [TIME_WIDTH-1:0] press_q;
	logic                  pend_q;

	logic                  level_n;
	logic [TIME_WIDTH-1:0] start_n;
	logic [TIME_WIDTH-1:0] press_n;
	logic                  pend_n;
	logic [TIME_WIDTH-1:0] since_start;
	logic [TIME_WIDTH-1:0] since_press;
	logic                  in_window;

	// Elapsed times, modulo the timestamp width
	assign since_start = now_t - start_q;
	assign since_press = now_t - press_q;
	assign in_window   = (since_press <= window_t);

	// Debounce and pair the press edges
	always_comb begin
		level_n = level_q;
		start_n = start_q;
		press_n = press_q;
		pend_n  = pend_q;
		fire    = 1'b0;
		if (raw != level_q) begin
			if (start_q == '0) begin
				start_n = now_t;
			end else if (since_start >= debounce_t) begin
				level_n = raw;
				start_n = '0;
				if (raw) begin
					press_n = now_t;
					if (pend_q && in_window) begin
						pend_n = 1'b0;
						fire   = 1'b1;
					end else begin
						pend_n = 1'b1;
					end
				end
			end
		end else begin
			start_n = '0;
		end
		// Close a stale window unless a fresh press just opened one
		if (press_n == press_q && pend_q && !in_window && !fire) begin
			pend_n = 1'b0;
		end
	end

	// Commit the lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			start_q <= '0;
			press_q <= '0;
			pend_q  <= 1'b0;
		end else if (ctrl.cancel) begin
			pend_q <= 1'b0;
		end else if (ctrl.upd) begin
			level_q <= level_n;
			start_q <= start_n;
			press_q <= press_n;
			pend_q  <= pend_n;
		end
	end

	a_cancel_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cancel |=> !pend_q)
		else $error("pending press survived a cancel");

	a_fire_takes_press: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.upd && !ctrl.cancel && fire) |=> (level_q && !pend_q && start_q == '0))
		else $error("double-click did not settle the lane state");

endmodule

`default_nettype wire

// File: rtl/core/dddc_merge.sv
`default_nettype none

module dddc_merge
	import dddc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic func,
	output logic      in_ready,
	input  wire logic fire_first,
	input  wire logic fire_second,
	output lane_ctrl_t ctrl_first,
	output lane_ctrl_t ctrl_second,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic      fired,
	output logic      which_button
);

	logic out_valid_q;
	logic fired_q;
	logic which_q;
	logic accept;
	logic poll;
	logic fired_n;
	logic which_n;

	// Take a new transaction whenever the output slot is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign poll     = (func == FUNC_POLL);

	// Lane control: the first button wins, the second holds when the first fires
	always_comb begin
		ctrl_first.upd     = accept && poll;
		ctrl_first.cancel  = accept && !poll;
		ctrl_second.upd    = accept && poll && !fire_first;
		ctrl_second.cancel = accept && !poll;
	end

	// Combine the lane findings into one result
	always_comb begin
		fired_n = 1'b0;
		which_n = BUTTON_FIRST;
		if (poll) begin
			if (fire_first) begin
				fired_n = 1'b1;
				which_n = BUTTON_FIRST;
			end else if (fire_second) begin
				fired_n = 1'b1;
				which_n = BUTTON_SECOND;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fired_q <= fired_n;
			which_q <= which_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign fired        = fired_q;
	assign which_button = which_q;

	a_second_yields: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl_second.upd && fire_first))
		else $error("second button updated in a poll the first button fired");

	a_idle_selector: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !fired_q) |-> (which_q == BUTTON_FIRST))
		else $error("button selector set without a double-click");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !poll) |=> (out_valid_q && !fired_q))
		else $error("cancel transaction produced a double-click");

endmodule

`default_nettype wire

// File: rtl/core/debounced_double_click_detector.sv
`default_nettype none

// Debounced double-click detector for two buttons. Each input transaction is
// either a poll (s_tuser = 0) carrying a millisecond timestamp and the raw
// pressed level of both buttons, or a cancel (s_tuser = 1) that drops any
// pending first press on both buttons. Every transaction yields exactly one
// result transaction: m_tdata[0] reports a double-click and m_tuser names the
// button, the first button taking priority. A poll is handled by two lanes,
// one per button, whose state registers update at the accepting edge; the
// result appears in the output register on the next cycle. The block takes one
// transaction per cycle as long as results are taken; a result waiting in the
// output register stalls the input only until it leaves. Registers are written
// via the cfg channel (index 0: debounce time, index 1: pair window, both in
// ms) by the user only while no transaction is in flight, which is unenforced.

module debounced_double_click_detector
	import dddc_pkg::*;
#(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// Input stream
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// [31:0] now_ms, [32] first_raw_pressed, [33] second_raw_pressed, [39:34] zero
	input  wire logic [S_TDATA_WIDTH-1:0]   s_tdata,
	// [0] func
	input  wire logic                       s_tuser,
	// Result stream
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// [0] fired, [7:1] zero
	output logic [M_TDATA_WIDTH-1:0]        m_tdata,
	// [0] which_button
	output logic                            m_tuser,
	// Configuration writes
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [CFG_WIDTH-1:0]       cfg_data
);

	logic [CFG_WIDTH-1:0]            debounce_q;
	logic [CFG_WIDTH-1:0]            window_q;
	logic [TIME_WIDTH+NOW_WIDTH-1:0] now_ext;
	logic [TIME_WIDTH+CFG_WIDTH-1:0] debounce_ext;
	logic [TIME_WIDTH+CFG_WIDTH-1:0] window_ext;
	logic [TIME_WIDTH-1:0]           now_t;
	logic [TIME_WIDTH-1:0]           debounce_t;
	logic [TIME_WIDTH-1:0]           window_t;
	lane_ctrl_t                      ctrl_first;
	lane_ctrl_t                      ctrl_second;
	logic                            fire_first;
	logic                            fire_second;
	logic                            fired;

	// Register writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= CFG_WIDTH'(50);
			window_q   <= CFG_WIDTH'(400);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEBOUNCE_TIME: debounce_q <= cfg_data;
				CFG_PAIR_WINDOW:   window_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Fit the timestamp and limits to the time width
	assign now_ext      = {{TIME_WIDTH{1'b0}}, s_tdata[NOW_WIDTH-1:0]};
	assign debounce_ext = {{TIME_WIDTH{1'b0}}, debounce_q};
	assign window_ext   = {{TIME_WIDTH{1'b0}}, window_q};
	assign now_t        = now_ext[TIME_WIDTH-1:0];
	assign debounce_t   = debounce_ext[TIME_WIDTH-1:0];
	assign window_t     = window_ext[TIME_WIDTH-1:0];

	dddc_lane #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_lane_first (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl_first),
		.now_t      (now_t),
		.raw        (s_tdata[FIRST_RAW_BIT]),
		.debounce_t (debounce_t),
		.window_t   (window_t),
		.fire       (fire_first)
	);

	dddc_lane #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_lane_second (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl_second),
		.now_t      (now_t),
		.raw        (s_tdata[SECOND_RAW_BIT]),
		.debounce_t (debounce_t),
		.window_t   (window_t),
		.fire       (fire_second)
	);

	dddc_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.func         (s_tuser),
		.in_ready     (s_tready),
		.fire_first   (fire_first),
		.fire_second  (fire_second),
		.ctrl_first   (ctrl_first),
		.ctrl_second  (ctrl_second),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.fired        (fired),
		.which_button (m_tuser)
	);

	assign m_tdata = {{(M_TDATA_WIDTH-1){1'b0}}, fired};

endmodule

`default_nettype wire
